/* sv/contiguous_block_allocator_defines.svh */
// Assertion macros for the contiguous block allocator.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CBA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cba assertion failed");

// Antecedent implies consequent in the next cycle.
`define CBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cba assertion failed");

`endif

/* sv/cba_pkg.sv */
// Shared types and constants of the contiguous block allocator.
// Used by every module of the block; depends on nothing.
package cba_pkg;

    localparam int NUM_BLOCKS_DEF = 128;
    localparam int MAX_FILES_DEF  = 32;

    localparam int NAME_W   = 64;
    localparam int START_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd5;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } dir_entry_t;

    // A lookup query as it travels down the directory chain.
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [NAME_W-1:0]  key;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } dir_token_t;

endpackage

/* sv/cba_occ.sv */
// Occupancy bitmap with registered range mask and chunked overlap check.
// Depends on cba_pkg.
module cba_occ import cba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [START_W-1:0] start,
    input  logic [COUNT_W-1:0] count,
    input  logic               mark,
    output logic               hit
);

    localparam int EW    = $clog2(NUM_BLOCKS + 384);
    localparam int CHUNK = 64;
    localparam int NCH   = (NUM_BLOCKS + CHUNK - 1) / CHUNK;

    logic [NUM_BLOCKS-1:0] occ_reg;
    logic [NUM_BLOCKS-1:0] mask_reg;
    logic [NUM_BLOCKS-1:0] mask_next;
    logic [NCH*CHUNK-1:0]  hit_bits;
    logic [NCH-1:0]        chunk_reg;
    logic [EW-1:0]         lo;
    logic [EW-1:0]         hi;

    assign lo = EW'(start);
    assign hi = EW'(start) + EW'(count);

    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_mask
        assign mask_next[i] = (EW'(i) >= lo) && (EW'(i) < hi);
    end

    assign hit_bits = (NCH*CHUNK)'(occ_reg & mask_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (mark) begin
            occ_reg <= occ_reg | mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mask_reg <= mask_next;
        end
    end

    for (genvar c = 0; c < NCH; c++) begin : g_chunk
        always_ff @(posedge aclk) begin
            chunk_reg[c] <= |hit_bits[c*CHUNK +: CHUNK];
        end
    end

    assign hit = |chunk_reg;

endmodule

/* sv/cba_cell.sv */
// One directory cell: holds one entry and compares the passing lookup word.
// Depends on cba_pkg.
module cba_cell import cba_pkg::*; #(
    parameter int MAX_FILES = MAX_FILES_DEF,
    parameter int INDEX     = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dir_token_t                       tok_i,
    output dir_token_t                       tok_o,
    input  logic                             wr_en,
    input  dir_entry_t                       wr_entry,
    input  logic [$clog2(MAX_FILES+1)-1:0]   file_total
);

    localparam int CW = $clog2(MAX_FILES + 1);

    dir_entry_t entry_reg;
    dir_token_t tok_reg;
    dir_token_t tok_next;
    logic       live;

    assign live = CW'(INDEX) < file_total;

    always_comb begin
        tok_next = tok_i;
        if (tok_i.vld && !tok_i.hit && live && (entry_reg.name == tok_i.key)) begin
            tok_next.hit   = 1'b1;
            tok_next.start = entry_reg.start;
            tok_next.count = entry_reg.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (file_total == CW'(INDEX))) begin
            entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

/* sv/cba_dir.sv */
// File directory: a chain of cells with the entry count register.
// Depends on cba_pkg and cba_cell.
module cba_dir import cba_pkg::*; #(
    parameter int MAX_FILES = MAX_FILES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dir_token_t                       tok_i,
    output dir_token_t                       tok_o,
    input  logic                             wr_en,
    input  dir_entry_t                       wr_entry,
    output logic [$clog2(MAX_FILES+1)-1:0]   file_total,
    output logic                             full
);

    localparam int CW = $clog2(MAX_FILES + 1);

    logic [CW-1:0] file_total_reg;
    dir_token_t    tok_chain [MAX_FILES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_total_reg <= '0;
        end else if (wr_en) begin
            file_total_reg <= file_total_reg + CW'(1);
        end
    end

    assign file_total = file_total_reg;
    assign full       = file_total_reg == CW'(MAX_FILES);

    assign tok_chain[0] = tok_i;

    for (genvar k = 0; k < MAX_FILES; k++) begin : g_cell
        cba_cell #(
            .MAX_FILES (MAX_FILES),
            .INDEX     (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_i      (tok_chain[k]),
            .tok_o      (tok_chain[k+1]),
            .wr_en      (wr_en),
            .wr_entry   (wr_entry),
            .file_total (file_total_reg)
        );
    end

    assign tok_o = tok_chain[MAX_FILES];

endmodule

/* sv/contiguous_block_allocator.sv */
// Contiguous block allocator top level: sequencer, bitmap and directory chain.
// Depends on cba_pkg, cba_occ, cba_dir and contiguous_block_allocator_defines.svh.
//
// Channel  Dir  tdata (low bit first)                        tuser
// s_       in   file_name[63:0] first_block[70:64]          func[0]
//               block_count[78:71], bit 79 zero
// m_       out  found_start[6:0] found_count[14:7], bit 15  status[2:0]
//
// An allocate word passes the registered bitmap mask, then the registered
// chunked overlap check, before its status is taken in S_CHECK.
// A lookup word makes its trip down the directory chain, registered in each
// cell, one cell per cycle. One word is in work at a time.
// Reset is synchronous and clears the bitmap and the entry count.
// A result held by m_tready low keeps the next result waiting, not the next input.
`include "contiguous_block_allocator_defines.svh"

module contiguous_block_allocator import cba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int MAX_FILES  = MAX_FILES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // file_name, first_block, block_count
    input  logic [0:0]           s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // found_start, found_count
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int EW = $clog2(NUM_BLOCKS + 384);
    localparam int CW = $clog2(MAX_FILES + 1);

    typedef enum logic [2:0] {S_IDLE, S_WAIT, S_CHECK, S_SCAN, S_DONE} state_t;

    state_t              state_reg;
    logic [NAME_W-1:0]   req_name_reg;
    logic [START_W-1:0]  req_start_reg;
    logic [COUNT_W-1:0]  req_count_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [START_W-1:0]  res_start_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [START_W-1:0]  m_start_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                s_accept;
    logic                in_func;
    logic [NAME_W-1:0]   in_name;
    logic [START_W-1:0]  in_start;
    logic [COUNT_W-1:0]  in_count;
    logic                occ_hit;
    logic                range_bad;
    logic [STATUS_W-1:0] alloc_status;
    logic                alloc_commit;
    dir_token_t          tok_in;
    dir_token_t          tok_out;
    dir_entry_t          wr_entry;
    logic [CW-1:0]       file_total;
    logic                dir_full;

    assign in_func  = s_tuser[0];
    assign in_name  = s_tdata[NAME_W-1:0];
    assign in_start = s_tdata[NAME_W +: START_W];
    assign in_count = s_tdata[NAME_W+START_W +: COUNT_W];

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign range_bad = (EW'(req_start_reg) + EW'(req_count_reg)) > EW'(NUM_BLOCKS);

    always_comb begin
        if (range_bad) begin
            alloc_status = ST_OUT_OF_RANGE;
        end else if (occ_hit) begin
            alloc_status = ST_OCCUPIED;
        end else if (dir_full) begin
            alloc_status = ST_TABLE_FULL;
        end else begin
            alloc_status = ST_ALLOCATED;
        end
    end

    assign alloc_commit = (state_reg == S_CHECK) && (alloc_status == ST_ALLOCATED);

    always_comb begin
        tok_in       = '0;
        tok_in.vld   = s_accept && (in_func == FUNC_LOOKUP);
        tok_in.key   = in_name;
    end

    assign wr_entry.name  = req_name_reg;
    assign wr_entry.start = req_start_reg;
    assign wr_entry.count = req_count_reg;

    cba_occ #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_occ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_accept && (in_func == FUNC_ALLOC)),
        .start   (in_start),
        .count   (in_count),
        .mark    (alloc_commit),
        .hit     (occ_hit)
    );

    cba_dir #(
        .MAX_FILES (MAX_FILES)
    ) u_dir (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tok_i      (tok_in),
        .tok_o      (tok_out),
        .wr_en      (alloc_commit),
        .wr_entry   (wr_entry),
        .file_total (file_total),
        .full       (dir_full)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg != S_DONE) && m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        req_name_reg  <= in_name;
                        req_start_reg <= in_start;
                        req_count_reg <= in_count;
                        state_reg     <= (in_func == FUNC_LOOKUP) ? S_SCAN : S_WAIT;
                    end
                end
                S_WAIT: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    res_status_reg <= alloc_status;
                    res_start_reg  <= '0;
                    res_count_reg  <= '0;
                    state_reg      <= S_DONE;
                end
                S_SCAN: begin
                    if (tok_out.vld) begin
                        res_status_reg <= tok_out.hit ? ST_FOUND : ST_NOT_FOUND;
                        res_start_reg  <= tok_out.start;
                        res_count_reg  <= tok_out.count;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_start_reg  <= res_start_reg;
                        m_count_reg  <= res_count_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_start_reg});

    `CBA_ASSERT_SAME(a_commit_not_full, aclk, aresetn, alloc_commit, !dir_full)
    `CBA_ASSERT_SAME(a_token_in_scan, aclk, aresetn, tok_out.vld, state_reg == S_SCAN)
    `CBA_ASSERT_NEXT(a_total_grows, aclk, aresetn, alloc_commit, file_total == $past(file_total) + 1'b1)
    `CBA_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_accept, !s_tready)

endmodule

/* dv/tb.sv */
// Self-checking testbench for contiguous_block_allocator: directed and random
// allocate and lookup words under several traffic phases, checked by a scoreboard.
// Depends on cba_pkg and the contiguous_block_allocator RTL.
module tb import cba_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PER_PHASE = 270;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 40;

    class alloc_scoreboard;
        typedef struct {
            logic [STATUS_W-1:0] status;
            logic [START_W-1:0]  fstart;
            logic [COUNT_W-1:0]  fcount;
        } reply_t;

        bit                 taken[NUM_BLOCKS_DEF];
        logic [NAME_W-1:0]  dir_name[MAX_FILES_DEF];
        logic [START_W-1:0] dir_start[MAX_FILES_DEF];
        logic [COUNT_W-1:0] dir_count[MAX_FILES_DEF];
        int                 file_total;
        reply_t             replies[$];
        int                 errors;
        int                 checked;
        int                 granted;
        int                 hits;
        int                 full_refusals;

        function int pending();
            return replies.size();
        endfunction

        function void note_input(logic func, logic [NAME_W-1:0] name,
                                 logic [START_W-1:0] first, logic [COUNT_W-1:0] len);
            reply_t r;
            int     i;
            bit     clash;
            r.status = ST_NOT_FOUND;
            r.fstart = '0;
            r.fcount = '0;
            clash    = 1'b0;
            if (func == FUNC_ALLOC) begin
                if (int'(first) + int'(len) > NUM_BLOCKS_DEF) begin
                    r.status = ST_OUT_OF_RANGE;
                end else begin
                    for (i = 0; i < int'(len); i++)
                        if (taken[int'(first) + i]) clash = 1'b1;
                    if (clash) begin
                        r.status = ST_OCCUPIED;
                    end else if (file_total >= MAX_FILES_DEF) begin
                        r.status = ST_TABLE_FULL;
                        full_refusals++;
                    end else begin
                        for (i = 0; i < int'(len); i++) taken[int'(first) + i] = 1'b1;
                        dir_name[file_total]  = name;
                        dir_start[file_total] = first;
                        dir_count[file_total] = len;
                        file_total++;
                        r.status = ST_ALLOCATED;
                        granted++;
                    end
                end
            end else begin
                for (i = 0; i < file_total; i++) begin
                    if (dir_name[i] == name) begin
                        r.status = ST_FOUND;
                        r.fstart = dir_start[i];
                        r.fcount = dir_count[i];
                        hits++;
                        break;
                    end
                end
            end
            replies.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [START_W-1:0] fstart,
                          logic [COUNT_W-1:0] fcount);
            reply_t r;
            if (replies.size() == 0) begin
                report($sformatf("unrequested word status=%0d", status));
            end else begin
                r = replies.pop_front();
                checked++;
                if (status !== r.status)
                    report($sformatf("status got %0d expected %0d", status, r.status));
                if (fstart !== r.fstart)
                    report($sformatf("found_start got %0d expected %0d", fstart, r.fstart));
                if (fcount !== r.fcount)
                    report($sformatf("found_count got %0d expected %0d", fcount, r.fcount));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    alloc_scoreboard   sb;
    logic [NAME_W-1:0] name_pool[$];
    int                sender_idle_pct;
    int                stall_pct;
    int                hold_left;
    int                cycles;
    int                words_sent;

    contiguous_block_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[START_W-1:0],
                            m_tdata[START_W+COUNT_W-1:START_W]);
    end

    task send_word(logic func, logic [NAME_W-1:0] name, logic [START_W-1:0] first,
                   logic [COUNT_W-1:0] len);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len, first, name};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(func, name, first, len);
        words_sent++;
        if (func == FUNC_ALLOC) name_pool.push_back(name);
    endtask

    task wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function logic [NAME_W-1:0] pick_name(int known_pct);
        logic [NAME_W-1:0] name;
        int                sel;
        sel = $urandom_range(0, 99);
        if (name_pool.size() == 0 || sel >= known_pct) begin
            name = {$urandom, $urandom};
            if (sel % 4 == 0) name[NAME_W-1:32] = '0;
        end else begin
            name = name_pool[$urandom_range(0, name_pool.size() - 1)];
            if (sel % 10 == 0) name = name ^ (64'd1 << $urandom_range(0, NAME_W - 1));
        end
        return name;
    endfunction

    task send_random_word();
        logic [COUNT_W-1:0] len;
        int                 sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) len = COUNT_W'($urandom_range(0, 3));
        else if (sel < 90) len = COUNT_W'($urandom_range(0, 16));
        else len = COUNT_W'($urandom_range(0, NUM_BLOCKS_DEF));
        if ($urandom_range(0, 99) < 45)
            send_word(FUNC_ALLOC, pick_name(50),
                      START_W'($urandom_range(0, NUM_BLOCKS_DEF - 1)), len);
        else
            send_word(FUNC_LOOKUP, pick_name(80), START_W'($urandom), COUNT_W'($urandom));
    endtask

    task run_directed();
        logic [NAME_W-1:0] ones;
        logic [NAME_W-1:0] alpha;
        logic [NAME_W-1:0] beta;
        ones  = '1;
        alpha = 64'h0000_0061_6c70_6861;
        beta  = 64'h5555_aaaa_0f0f_f0f0;
        send_word(FUNC_LOOKUP, ones, 7'd0, 8'd0);
        send_word(FUNC_ALLOC, '0, 7'd0, 8'd0);
        send_word(FUNC_LOOKUP, '0, 7'd127, 8'd255);
        send_word(FUNC_ALLOC, ones, 7'd127, 8'd1);
        send_word(FUNC_ALLOC, alpha, 7'd127, 8'd2);
        send_word(FUNC_ALLOC, alpha, 7'd120, 8'd8);
        send_word(FUNC_ALLOC, alpha, 7'd121, 8'd8);
        send_word(FUNC_ALLOC, alpha, 7'd0, 8'd128);
        send_word(FUNC_ALLOC, alpha, 7'd10, 8'd5);
        send_word(FUNC_ALLOC, alpha, 7'd14, 8'd3);
        send_word(FUNC_ALLOC, alpha, 7'd15, 8'd3);
        send_word(FUNC_LOOKUP, alpha, 7'd0, 8'd0);
        send_word(FUNC_LOOKUP, ones, 7'd0, 8'd0);
        send_word(FUNC_LOOKUP, 64'h8000_0000_0000_0001, 7'd0, 8'd0);
        send_word(FUNC_ALLOC, beta, 7'd64, 8'd64);
        send_word(FUNC_ALLOC, beta, 7'd64, 8'd32);
        send_word(FUNC_LOOKUP, beta, 7'd0, 8'd0);
        send_word(FUNC_ALLOC, ones, 7'd127, 8'd0);
        send_word(FUNC_LOOKUP, ones, 7'd0, 8'd0);
    endtask

    initial begin
        int sender_pcts[4];
        int stall_pcts[4];
        int ph;
        int n;
        sender_pcts     = '{0, 67, 0, 11};
        stall_pcts      = '{0, 0, 67, 11};
        sb              = new;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = 0;
        cycles          = 0;
        words_sent      = 0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        wait_drained();
        for (ph = 0; ph < 4; ph++) begin
            sender_idle_pct = sender_pcts[ph];
            stall_pct       = stall_pcts[ph];
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 0 && n == 100) hold_left = LONG_HOLD;
                if (ph == 1 && n == 135) wait_drained();
                send_random_word();
            end
            wait_drained();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d words, checked %0d results over four traffic phases.",
                 words_sent, sb.checked);
        $display("Granted %0d allocations, %0d lookup hits, %0d refusals on a full directory.",
                 sb.granted, sb.hits, sb.full_refusals);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
